/* rtl/kcc_pkg.sv */
// Shared types and constants for the knob rotation and click classifier.
package kcc_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CLICK_W = 2;

    localparam logic signed [COUNT_W-1:0] WRAP_LIMIT     = 16'sd1000;
    localparam logic signed [COUNT_W-1:0] WRAP_LIMIT_NEG = -16'sd1000;

    localparam logic [CFG_W-1:0]   LONG_PRESS_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0]   DOUBLE_CLICK_RESET = 16'd300;
    localparam logic [CLICK_W-1:0] CLICKS_MAX         = 2'd3;

    typedef enum logic [0:0] {
        CFG_LONG_PRESS_LIMIT    = 1'b0,
        CFG_DOUBLE_CLICK_WINDOW = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_UP    = 3'd2,
        EV_ENTER = 3'd3,
        EV_BACK  = 3'd4
    } event_t;

endpackage

/* rtl/kcc_stream_if.sv */
// Valid/ready channel interfaces for poll samples and classified events.
interface kcc_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [kcc_pkg::COUNT_W-1:0] encoder_count;
    logic                               button_level;
    logic        [kcc_pkg::STAMP_W-1:0] now_ms;
    logic                               read_ok;

    modport source (output valid, encoder_count, button_level, now_ms, read_ok,
                    input ready);
    modport sink   (input valid, encoder_count, button_level, now_ms, read_ok,
                    output ready);
    modport mon    (input valid, ready, encoder_count, button_level, now_ms, read_ok);
endinterface

interface kcc_event_if;
    logic                  valid;
    logic                  ready;
    kcc_pkg::event_t       event_res;

    modport source (output valid, event_res, input ready);
    modport sink   (input valid, event_res, output ready);
    modport mon    (input valid, ready, event_res);
endinterface

/* rtl/knob_rotation_and_click_classifier_top.sv */
// Knob rotation and click classifier: poll samples in, navigation events out.
//
//  channel     dir  handshake       payload
//  sample_ch   in   valid/ready     encoder_count, button_level, now_ms, read_ok
//  event_ch    out  valid/ready     event_res
//  cfg         in   cfg_we          cfg_index, cfg_data
//
//  One sample per cycle unless stalled; sample register feeds the event register.
//  The rate is set by the single classify stage between sample and event registers.
//  Every sample transfer yields exactly one event transfer.
//  A stalled event register holds the sample register; both drain in order.
//  Reset clears valid flags, click state and loads default limits.
module knob_rotation_and_click_classifier_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  kcc_pkg::cfg_index_t          cfg_index,
    input  logic [kcc_pkg::CFG_W-1:0]    cfg_data,
    kcc_sample_if.sink                   sample_ch,
    kcc_event_if.source                  event_ch
);

    logic                               s1_valid_reg;
    logic signed [kcc_pkg::COUNT_W-1:0] s1_count_reg;
    logic                               s1_btn_reg;
    logic        [kcc_pkg::STAMP_W-1:0] s1_now_reg;
    logic                               s1_ok_reg;

    logic                               out_valid_reg;
    kcc_pkg::event_t                    out_event_reg;

    logic [kcc_pkg::CFG_W-1:0]          long_press_limit_reg;
    logic [kcc_pkg::CFG_W-1:0]          double_click_window_reg;

    logic signed [kcc_pkg::COUNT_W-1:0] last_count_reg, last_count_next;
    logic                               pressed_reg, pressed_next;
    logic                               long_handled_reg, long_handled_next;
    logic [kcc_pkg::CLICK_W-1:0]        clicks_reg, clicks_next;
    logic [kcc_pkg::STAMP_W-1:0]        press_stamp_reg, press_stamp_next;
    logic [kcc_pkg::STAMP_W-1:0]        release_stamp_reg, release_stamp_next;
    kcc_pkg::event_t                    event_next;

    logic                               advance;
    logic                               sample_xfer;
    logic signed [kcc_pkg::COUNT_W-1:0] diff;
    logic                               rotated;
    logic                               turn_down;
    logic                               press_edge;
    logic                               held;
    logic [kcc_pkg::STAMP_W-1:0]        held_time;
    logic [kcc_pkg::STAMP_W-1:0]        idle_time;

    assign advance           = !out_valid_reg || event_ch.ready;
    assign sample_ch.ready   = !s1_valid_reg || advance;
    assign sample_xfer       = sample_ch.valid && sample_ch.ready;
    assign event_ch.valid    = out_valid_reg;
    assign event_ch.event_res = out_event_reg;

    assign diff      = s1_count_reg - last_count_reg;
    assign rotated   = (diff != '0);
    assign turn_down = ((diff > 0) && (diff <= kcc_pkg::WRAP_LIMIT))
                       || (diff < kcc_pkg::WRAP_LIMIT_NEG);

    always_comb
    begin
        last_count_next    = last_count_reg;
        pressed_next       = pressed_reg;
        long_handled_next  = long_handled_reg;
        clicks_next        = clicks_reg;
        press_stamp_next   = press_stamp_reg;
        release_stamp_next = release_stamp_reg;
        event_next         = kcc_pkg::EV_NONE;
        press_edge         = 1'b0;
        held               = 1'b0;
        held_time          = '0;
        idle_time          = '0;

        if (s1_ok_reg)
        begin
            if (rotated)
            begin
                last_count_next = s1_count_reg;
                event_next      = turn_down ? kcc_pkg::EV_DOWN : kcc_pkg::EV_UP;
            end
            else
            begin
                press_edge = s1_btn_reg && !pressed_reg;
                held       = pressed_reg || s1_btn_reg;
                if (press_edge)
                begin
                    press_stamp_next  = s1_now_reg;
                    long_handled_next = 1'b0;
                end

                held_time = s1_now_reg - press_stamp_next;
                if (held && !long_handled_next
                    && (held_time > {{(kcc_pkg::STAMP_W-kcc_pkg::CFG_W){1'b0}},
                                     long_press_limit_reg}))
                begin
                    event_next        = kcc_pkg::EV_BACK;
                    long_handled_next = 1'b1;
                    clicks_next       = '0;
                end

                pressed_next = held;
                if (!s1_btn_reg && held)
                begin
                    pressed_next = 1'b0;
                    if (!long_handled_next)
                    begin
                        if (clicks_next != kcc_pkg::CLICKS_MAX)
                        begin
                            clicks_next = clicks_next + 1'b1;
                        end
                        release_stamp_next = s1_now_reg;
                    end
                end

                idle_time = s1_now_reg - release_stamp_next;
                if ((clicks_next != '0) && !pressed_next)
                begin
                    if (clicks_next == 2'd1)
                    begin
                        if (idle_time > {{(kcc_pkg::STAMP_W-kcc_pkg::CFG_W){1'b0}},
                                         double_click_window_reg})
                        begin
                            event_next  = kcc_pkg::EV_ENTER;
                            clicks_next = '0;
                        end
                    end
                    else
                    begin
                        event_next  = kcc_pkg::EV_BACK;
                        clicks_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_limit_reg    <= kcc_pkg::LONG_PRESS_RESET;
            double_click_window_reg <= kcc_pkg::DOUBLE_CLICK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kcc_pkg::CFG_LONG_PRESS_LIMIT:    long_press_limit_reg    <= cfg_data;
                kcc_pkg::CFG_DOUBLE_CLICK_WINDOW: double_click_window_reg <= cfg_data;
                default:                          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_count_reg    <= '0;
            pressed_reg       <= 1'b0;
            long_handled_reg  <= 1'b0;
            clicks_reg        <= '0;
            press_stamp_reg   <= '0;
            release_stamp_reg <= '0;
        end
        else
        begin
            if (sample_ch.ready)
            begin
                s1_valid_reg <= sample_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    last_count_reg    <= last_count_next;
                    pressed_reg       <= pressed_next;
                    long_handled_reg  <= long_handled_next;
                    clicks_reg        <= clicks_next;
                    press_stamp_reg   <= press_stamp_next;
                    release_stamp_reg <= release_stamp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            s1_count_reg <= sample_ch.encoder_count;
            s1_btn_reg   <= sample_ch.button_level;
            s1_now_reg   <= sample_ch.now_ms;
            s1_ok_reg    <= sample_ch.read_ok;
        end
        if (advance && s1_valid_reg)
        begin
            out_event_reg <= event_next;
        end
    end

endmodule

/* rtl/kcc_checker.sv */
// Port-level checks for the knob rotation and click classifier, bound to the top level.
module kcc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            sample_ready,
    input logic            event_valid,
    input logic            event_ready,
    input kcc_pkg::event_t event_res
);

    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !event_ready) |=>
            (event_valid && $stable(event_res)))
        else $error("stalled event changed");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> (event_res <= kcc_pkg::EV_BACK))
        else $error("event code out of range");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !event_valid)
        else $error("event valid during reset");

    a_ready_when_empty: assert property (@(posedge clk)
        !event_valid |-> sample_ready)
        else $error("sample stalled while event register empty");

endmodule

bind knob_rotation_and_click_classifier_top kcc_checker u_kcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ch.ready),
    .event_valid  (event_ch.valid),
    .event_ready  (event_ch.ready),
    .event_res    (event_ch.event_res)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the knob rotation and click classifier top level.
module testbench;

    typedef logic signed [kcc_pkg::COUNT_W-1:0] count_t;
    typedef logic [kcc_pkg::STAMP_W-1:0]        stamp_t;
    typedef logic [kcc_pkg::CFG_W-1:0]          cfg_t;
    typedef logic [kcc_pkg::CLICK_W-1:0]        click_t;

    typedef struct {
        count_t count;
        logic   button;
        stamp_t stamp;
        logic   ok;
    } poll_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    kcc_pkg::cfg_index_t  cfg_index;
    cfg_t                 cfg_data;

    kcc_sample_if sample_ch();
    kcc_event_if  event_ch();

    knob_rotation_and_click_classifier_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .event_ch  (event_ch)
    );

    poll_t           pending_polls[$];
    kcc_pkg::event_t expected_events[$];
    int              mismatches = 0;
    int              send_hold  = 0;
    int              stall_hold = 0;
    bit              idling     = 1'b1;

    // knob and button state tracked for event prediction
    cfg_t   long_limit = kcc_pkg::LONG_PRESS_RESET;
    cfg_t   dbl_window = kcc_pkg::DOUBLE_CLICK_RESET;
    count_t knob_last  = '0;
    logic   btn_held   = 1'b0;
    logic   long_done  = 1'b0;
    click_t click_cnt  = '0;
    stamp_t press_at   = '0;
    stamp_t release_at = '0;

    // stimulus cursor
    count_t gen_count = '0;
    stamp_t gen_now   = '0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = kcc_pkg::CFG_LONG_PRESS_LIMIT;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.encoder_count = '0;
        sample_ch.button_level = 1'b0;
        sample_ch.now_ms       = '0;
        sample_ch.read_ok      = 1'b0;
        event_ch.ready         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL knob_rotation_and_click_classifier_top");
        $finish;
    end

    function automatic kcc_pkg::event_t classify_poll(poll_t p);
        count_t          delta;
        kcc_pkg::event_t ev;
        ev = kcc_pkg::EV_NONE;
        if (!p.ok)
            return kcc_pkg::EV_NONE;
        delta = p.count - knob_last;
        if (delta != 0)
        begin
            knob_last = p.count;
            if (delta < kcc_pkg::WRAP_LIMIT_NEG)
                return kcc_pkg::EV_DOWN;
            if (delta > kcc_pkg::WRAP_LIMIT)
                return kcc_pkg::EV_UP;
            return (delta > 0) ? kcc_pkg::EV_DOWN : kcc_pkg::EV_UP;
        end
        if (p.button && !btn_held)
        begin
            btn_held  = 1'b1;
            press_at  = p.stamp;
            long_done = 1'b0;
        end
        if (btn_held && !long_done && stamp_t'(p.stamp - press_at) > stamp_t'(long_limit))
        begin
            ev        = kcc_pkg::EV_BACK;
            long_done = 1'b1;
            click_cnt = '0;
        end
        if (!p.button && btn_held)
        begin
            btn_held = 1'b0;
            if (!long_done)
            begin
                if (click_cnt < kcc_pkg::CLICKS_MAX)
                    click_cnt = click_cnt + 1'b1;
                release_at = p.stamp;
            end
        end
        if (click_cnt != 0 && !btn_held)
        begin
            if (click_cnt == 1)
            begin
                if (stamp_t'(p.stamp - release_at) > stamp_t'(dbl_window))
                begin
                    ev        = kcc_pkg::EV_ENTER;
                    click_cnt = '0;
                end
            end
            else
            begin
                ev        = kcc_pkg::EV_BACK;
                click_cnt = '0;
            end
        end
        return ev;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : poll_driver
        poll_t next_poll;
        if (rst_n && (!sample_ch.valid || sample_ch.ready))
        begin
            if (send_hold != 0)
            begin
                send_hold = send_hold - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_polls.size() != 0)
            begin
                next_poll = pending_polls.pop_front();
                sample_ch.valid         <= 1'b1;
                sample_ch.encoder_count <= next_poll.count;
                sample_ch.button_level  <= next_poll.button;
                sample_ch.now_ms        <= next_poll.stamp;
                sample_ch.read_ok       <= next_poll.ok;
                if (idling && $urandom_range(0, 5) == 0)
                    send_hold = $urandom_range(1, 11);
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : event_sink
        if (rst_n)
        begin
            if (stall_hold != 0)
            begin
                stall_hold = stall_hold - 1;
                event_ch.ready <= 1'b0;
            end
            else
            begin
                event_ch.ready <= 1'b1;
                if (idling && $urandom_range(0, 6) == 0)
                    stall_hold = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge clk)
    begin : transfer_monitor
        poll_t           seen;
        kcc_pkg::event_t want;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                seen.count  = sample_ch.encoder_count;
                seen.button = sample_ch.button_level;
                seen.stamp  = sample_ch.now_ms;
                seen.ok     = sample_ch.read_ok;
                expected_events.push_back(classify_poll(seen));
            end
            if (event_ch.valid && event_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("event %0d with nothing expected",
                                              event_ch.event_res));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_ch.event_res !== want)
                        report_mismatch($sformatf("event_res %0d, expected %0d",
                                                  event_ch.event_res, want));
                end
            end
        end
    end

    task automatic add_abs(count_t count, logic btn, stamp_t stamp, logic ok);
        poll_t p;
        p.count  = count;
        p.button = btn;
        p.stamp  = stamp;
        p.ok     = ok;
        pending_polls.push_back(p);
    endtask

    task automatic add_poll(logic btn, stamp_t dt);
        gen_now = gen_now + dt;
        add_abs(gen_count, btn, gen_now, 1'b1);
    endtask

    function automatic stamp_t near_limit(cfg_t lim);
        case ($urandom_range(0, 5))
            0:       return stamp_t'(lim);
            1:       return stamp_t'(lim) + 1;
            2:       return (lim == 0) ? '0 : stamp_t'(lim) - 1;
            3:       return stamp_t'(lim) + 2;
            default: return $urandom_range(0, 2 * stamp_t'(lim) + 8);
        endcase
    endfunction

    task automatic add_turn(logic btn);
        count_t step;
        case ($urandom_range(0, 11))
            0:       step = 16'sd1000;
            1:       step = -16'sd1000;
            2:       step = 16'sd1001;
            3:       step = -16'sd1001;
            4:       step = 16'sh8000;
            5, 6:    step = count_t'($urandom);
            default: step = count_t'($urandom_range(0, 1) ? $urandom_range(1, 4)
                                                          : -$urandom_range(1, 4));
        endcase
        if (step == 0)
            step = 16'sd1;
        gen_count = gen_count + step;
        add_poll(btn, $urandom_range(0, 20));
    endtask

    task automatic add_click();
        add_poll(1'b1, $urandom_range(1, 50));
        repeat ($urandom_range(0, 2)) add_poll(1'b1, $urandom_range(0, long_limit / 4));
        add_poll(1'b0, $urandom_range(0, long_limit / 4));
        add_poll(1'b0, near_limit(dbl_window));
        if ($urandom_range(0, 1))
            add_poll(1'b0, $urandom_range(0, dbl_window + 4));
    endtask

    task automatic add_double_click();
        add_poll(1'b1, $urandom_range(1, 50));
        add_poll(1'b0, $urandom_range(0, long_limit / 4));
        if ($urandom_range(0, 2) == 0)
            add_poll(1'b0, $urandom_range(0, dbl_window));
        add_poll(1'b1, $urandom_range(0, dbl_window));
        add_poll(1'b0, $urandom_range(0, long_limit / 4));
        add_poll(1'b0, $urandom_range(0, 10));
    endtask

    task automatic add_long_press();
        stamp_t hold_dt;
        stamp_t first;
        hold_dt = near_limit(long_limit);
        first   = $urandom_range(0, hold_dt);
        add_poll(1'b1, $urandom_range(1, 50));
        add_poll(1'b1, first);
        add_poll(1'b1, hold_dt - first);
        if ($urandom_range(0, 1))
            add_poll(1'b1, $urandom_range(0, 5));
        add_poll(1'b0, $urandom_range(0, 30));
        add_poll(1'b0, $urandom_range(0, dbl_window + 4));
    endtask

    task automatic add_gesture();
        case ($urandom_range(0, 15))
            0, 1, 2: add_click();
            3, 4:    add_double_click();
            5, 6:    add_long_press();
            7, 8, 9: add_turn($urandom_range(0, 3) == 0);
            10:      add_poll(1'b0, $urandom_range(0, dbl_window + 8));
            11:      add_abs(count_t'($urandom), 1'($urandom), $urandom, 1'b0);
            12:
            begin
                gen_count = count_t'($urandom);
                gen_now   = $urandom;
                add_poll(1'($urandom_range(0, 1)), '0);
            end
            13:
            begin
                if ($urandom_range(0, 1))
                    gen_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * long_limit + 2 * dbl_window);
                else
                    gen_now = gen_now - $urandom_range(1, 5000);
                add_click();
            end
            14:
            begin
                add_poll(1'b1, $urandom_range(1, 50));
                add_turn(1'b0);
                add_poll(1'b0, $urandom_range(0, 50));
            end
            default: add_poll(1'($urandom_range(0, 1)), $urandom);
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_polls.size() != 0 || sample_ch.valid || expected_events.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(kcc_pkg::cfg_index_t idx, cfg_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == kcc_pkg::CFG_LONG_PRESS_LIMIT)
            long_limit = val;
        else
            dbl_window = val;
    endtask

    task automatic run_phase(int polls, bit with_idling);
        idling = with_idling;
        while (pending_polls.size() < polls)
            add_gesture();
        drain();
    endtask

    initial
    begin : stimulus
        wait (rst_n === 1'b1);
        @(posedge clk);

        add_abs(16'sd5, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_abs(16'sd0, 1'b0, 32'd10, 1'b1);
        add_abs(16'sd1000, 1'b0, 32'd11, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd12, 1'b1);
        add_abs(16'sd1001, 1'b0, 32'd13, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd14, 1'b1);
        add_abs(16'sd32767, 1'b0, 32'd15, 1'b1);
        add_abs(-16'sd32768, 1'b0, 32'd16, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd17, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd100, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd150, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd450, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd451, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd500, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd520, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd540, 1'b1);
        add_abs(-16'sd5, 1'b0, 32'd545, 1'b0);
        add_abs(16'sd0, 1'b0, 32'd560, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd1000, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd2000, 1'b1);
        add_abs(16'sd0, 1'b1, 32'd2001, 1'b1);
        add_abs(16'sd0, 1'b0, 32'd2100, 1'b1);
        add_abs(16'sd0, 1'b1, 32'hFFFF_FF00, 1'b1);
        add_abs(16'sd0, 1'b0, 32'h0000_0010, 1'b1);
        add_abs(16'sd0, 1'b0, 32'h0000_0005, 1'b1);
        add_abs(16'sd0, 1'b1, 32'h0000_0100, 1'b1);
        add_abs(16'sd7, 1'b0, 32'h0000_0110, 1'b1);
        add_abs(16'sd7, 1'b0, 32'h0000_0120, 1'b1);
        gen_count = 16'sd7;
        gen_now   = 32'h0000_0200;
        drain();

        run_phase(320, 1'b1);

        write_reg(kcc_pkg::CFG_LONG_PRESS_LIMIT, 16'd0);
        write_reg(kcc_pkg::CFG_DOUBLE_CLICK_WINDOW, 16'd0);
        run_phase(320, 1'b1);

        write_reg(kcc_pkg::CFG_LONG_PRESS_LIMIT, 16'hFFFF);
        write_reg(kcc_pkg::CFG_DOUBLE_CLICK_WINDOW, 16'hFFFF);
        run_phase(320, 1'b1);

        write_reg(kcc_pkg::CFG_LONG_PRESS_LIMIT, cfg_t'($urandom_range(1, 200)));
        write_reg(kcc_pkg::CFG_DOUBLE_CLICK_WINDOW, cfg_t'($urandom_range(1, 200)));
        run_phase(320, 1'b0);

        write_reg(kcc_pkg::CFG_LONG_PRESS_LIMIT, 16'd20);
        write_reg(kcc_pkg::CFG_DOUBLE_CLICK_WINDOW, 16'hFFFF);
        run_phase(320, 1'b1);

        write_reg(kcc_pkg::CFG_LONG_PRESS_LIMIT, kcc_pkg::LONG_PRESS_RESET);
        write_reg(kcc_pkg::CFG_DOUBLE_CLICK_WINDOW, kcc_pkg::DOUBLE_CLICK_RESET);
        run_phase(300, 1'b0);

        if (mismatches == 0)
            $display("PASS knob_rotation_and_click_classifier_top");
        else
            $display("FAIL knob_rotation_and_click_classifier_top");
        $finish;
    end
endmodule
